/* hw/rtl/trml_pkg.sv */
// Package: widths, constants and shared types of the transfer rate meter/limiter.
package trml_pkg;
	localparam int WINDOW_SLOTS = 5;
	localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int TIME_W = 48;
	localparam int BYTES_W = 40;
	localparam int RATE_W = 31;
	localparam int CNT_W = 24;
	localparam int SUMB_W = BYTES_W + 7;
	localparam int SUMT_W = TIME_W + 7;
	// dividend for need = bytes*1e6 fits in 44 bits; speed dividend sumb*1e6 in 67
	localparam int DIVN_W = SUMB_W + 20;
	localparam int DIVD_W = SUMT_W;
	localparam int DCNT_W = $clog2(DIVN_W + 1);
	localparam logic [TIME_W-1:0] USEC_PER_SEC = TIME_W'(1000000);
	localparam logic [TIME_W-1:0] MAX_DELAY_US = TIME_W'(2000000);
	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

	localparam logic REQ_XFER = 1'b0;
	localparam logic REQ_RESET = 1'b1;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE_DOWN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE_UP = 1'b1;

	typedef struct packed {
		logic load;       // latch input transaction
		logic do_clear;   // reset-statistics update
		logic do_xfer;    // transfer update (accumulators, ring, activity)
		logic sum_clr;    // clear ring sums
		logic sum_add;    // add ring slot sum_idx
		logic div_start;  // start divider
		logic div_speed;  // 1: speed divide, 0: permit divide
		logic permit_upd; // apply permit update from quotient
		logic speed_upd;  // latch speed from quotient
		logic out_load;   // latch result register
		logic [SLOT_W-1:0] sum_idx;
	} trml_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic need_permit; // transfer request, valid previous event and cap nonzero
	} trml_sts_t;
endpackage

/* hw/rtl/trml_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
module trml_div
	import trml_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVN_W-1:0] num,
	input  logic [DIVD_W-1:0] den,
	output logic              busy,
	output logic [DIVN_W-1:0] quo
);
	logic [DCNT_W-1:0] cnt_q;
	logic [DIVD_W:0]   rem_q;
	logic [DIVN_W-1:0] quo_q;
	logic [DIVD_W-1:0] den_q;
	logic [DIVD_W:0]   trial;
	logic [DIVD_W:0]   diff;

	assign trial = {rem_q[DIVD_W-1:0], quo_q[DIVN_W-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DCNT_W'(DIVN_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!diff[DIVD_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[DIVN_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DIVN_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo = quo_q;
endmodule

/* hw/rtl/trml_datapath.sv */
// Datapath: per-direction statistics, ring, sums, divider and result register.
module trml_datapath
	import trml_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  trml_cmd_t         cmd,
	output trml_sts_t         sts,
	input  logic              cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [RATE_W-1:0] cfg_data,
	input  logic              req_type,
	input  logic              direction,
	input  logic [TIME_W-1:0] now_us,
	input  logic [CNT_W-1:0]  byte_count,
	output logic [RATE_W-1:0] speed_bytes_per_sec,
	output logic              next_valid,
	output logic [TIME_W-1:0] next_time_us,
	output logic [TIME_W-1:0] last_activity_us,
	output logic              limiting_active
);
	logic [RATE_W-1:0]  max_rate_q [2];
	logic [TIME_W-1:0]  prev_time_q [2];
	logic               prev_valid_q [2];
	logic [TIME_W-1:0]  acc_time_q [2];
	logic [BYTES_W-1:0] acc_bytes_q [2];
	logic [TIME_W-1:0]  win_time_q [2][WINDOW_SLOTS];
	logic [BYTES_W-1:0] win_bytes_q [2][WINDOW_SLOTS];
	logic [SLOT_W-1:0]  slot_q [2];
	logic [TIME_W-1:0]  permit_time_q [2];
	logic               permit_valid_q [2];
	logic [TIME_W-1:0]  act_time_q [2];

	logic               req_q, dir_q, hadprev_q;
	logic [TIME_W-1:0]  now_q, usec_q;
	logic [CNT_W-1:0]   bytes_q;
	logic [SUMT_W-1:0]  sumt_q;
	logic [SUMB_W-1:0]  sumb_q;
	logic [RATE_W-1:0]  speed_q;

	logic [TIME_W:0]    acc_t_sum;
	logic [BYTES_W:0]   acc_b_sum;
	logic [TIME_W-1:0]  acc_t_sat, usec;
	logic [BYTES_W-1:0] acc_b_sat;
	logic               dv_busy;
	logic [DIVN_W-1:0]  dv_num, dv_quo;
	logic [DIVD_W-1:0]  dv_den;
	logic [TIME_W-1:0]  half, need, delta, base;
	logic               need_big;

	assign usec = (now_us >= prev_time_q[direction]) ? now_us - prev_time_q[direction] : '0;
	assign acc_t_sum = {1'b0, acc_time_q[direction]} + {1'b0, usec};
	assign acc_b_sum = {1'b0, acc_bytes_q[direction]} + (BYTES_W+1)'(byte_count);
	assign acc_t_sat = acc_t_sum[TIME_W] ? {TIME_W{1'b1}} : acc_t_sum[TIME_W-1:0];
	assign acc_b_sat = acc_b_sum[BYTES_W] ? {BYTES_W{1'b1}} : acc_b_sum[BYTES_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < 2; d++) begin
				max_rate_q[d] <= '0;
				prev_time_q[d] <= '0;
				prev_valid_q[d] <= 1'b0;
				acc_time_q[d] <= '0;
				acc_bytes_q[d] <= '0;
				slot_q[d] <= '0;
				permit_time_q[d] <= '0;
				permit_valid_q[d] <= 1'b0;
				act_time_q[d] <= '0;
				for (int i = 0; i < WINDOW_SLOTS; i++) begin
					win_time_q[d][i] <= '0;
					win_bytes_q[d][i] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_MAX_RATE_DOWN: max_rate_q[0] <= cfg_data;
					CFG_MAX_RATE_UP:   max_rate_q[1] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.do_clear) begin
				for (int d = 0; d < 2; d++) begin
					prev_time_q[d] <= '0;
					prev_valid_q[d] <= 1'b0;
					acc_time_q[d] <= '0;
					acc_bytes_q[d] <= '0;
					permit_time_q[d] <= '0;
					permit_valid_q[d] <= 1'b0;
					act_time_q[d] <= now_us;
					for (int i = 0; i < WINDOW_SLOTS; i++) begin
						win_time_q[d][i] <= '0;
						win_bytes_q[d][i] <= '0;
					end
				end
			end
			if (cmd.do_xfer) begin
				prev_time_q[direction] <= now_us;
				prev_valid_q[direction] <= 1'b1;
				if (prev_valid_q[direction]) begin
					if (acc_t_sat > USEC_PER_SEC) begin
						win_time_q[direction][slot_q[direction]] <= acc_t_sat;
						win_bytes_q[direction][slot_q[direction]] <= acc_b_sat;
						slot_q[direction] <= (slot_q[direction] == SLOT_W'(WINDOW_SLOTS - 1))
							? '0 : slot_q[direction] + 1'b1;
						acc_time_q[direction] <= '0;
						acc_bytes_q[direction] <= '0;
					end else begin
						acc_time_q[direction] <= acc_t_sat;
						acc_bytes_q[direction] <= acc_b_sat;
					end
					if (max_rate_q[direction] == '0) begin
						permit_time_q[direction] <= '0;
						permit_valid_q[direction] <= 1'b0;
					end
				end
				if (byte_count != '0) act_time_q[direction] <= now_us;
			end
			if (cmd.permit_upd && need_big) begin
				permit_time_q[dir_q] <= base + delta;
				permit_valid_q[dir_q] <= 1'b1;
			end
		end
	end

	// Latched transaction and working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			dir_q <= direction;
			now_q <= now_us;
			bytes_q <= byte_count;
			usec_q <= usec;
			hadprev_q <= prev_valid_q[direction];
		end
		if (cmd.sum_clr) begin
			sumt_q <= '0;
			sumb_q <= '0;
		end else if (cmd.sum_add) begin
			sumt_q <= sumt_q + SUMT_W'(win_time_q[dir_q][cmd.sum_idx]);
			sumb_q <= sumb_q + SUMB_W'(win_bytes_q[dir_q][cmd.sum_idx]);
		end
		if (cmd.speed_upd) begin
			if (sumt_q == '0) speed_q <= '0;
			else if (dv_quo > DIVN_W'(RATE_MAX)) speed_q <= RATE_MAX;
			else speed_q <= dv_quo[RATE_W-1:0];
		end
	end

	assign dv_num = cmd.div_speed ? DIVN_W'(sumb_q) * DIVN_W'(USEC_PER_SEC)
		: DIVN_W'(bytes_q) * DIVN_W'(USEC_PER_SEC);
	assign dv_den = cmd.div_speed ? ((sumt_q == '0) ? DIVD_W'(1) : sumt_q)
		: DIVD_W'(max_rate_q[dir_q]);

	trml_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (dv_num),
		.den   (dv_den),
		.busy  (dv_busy),
		.quo   (dv_quo)
	);

	// need < 2^44, so TIME_W bits hold it
	assign need = dv_quo[TIME_W-1:0];
	assign half = usec_q >> 1;
	assign need_big = (need > half);
	assign delta = (((need - half) << 1) > MAX_DELAY_US) ? MAX_DELAY_US : ((need - half) << 1);
	assign base = permit_valid_q[dir_q] ? permit_time_q[dir_q] : now_q;

	assign sts.div_busy = dv_busy;
	assign sts.need_permit = (req_q == REQ_XFER) && hadprev_q && (max_rate_q[dir_q] != '0);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			speed_bytes_per_sec <= speed_q;
			next_valid <= permit_valid_q[dir_q];
			next_time_us <= permit_valid_q[dir_q] ? permit_time_q[dir_q] : '0;
			last_activity_us <= (act_time_q[0] > act_time_q[1]) ? act_time_q[0] : act_time_q[1];
			limiting_active <= (max_rate_q[0] != '0) || (max_rate_q[1] != '0);
		end
	end
endmodule

/* hw/rtl/trml_ctrl.sv */
// Controller: sequences update, permit divide, ring sum, speed divide, output.
module trml_ctrl
	import trml_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  logic      req_type,
	input  trml_sts_t sts,
	output trml_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PDIV = 3'd1;
	localparam logic [2:0] S_PWAIT = 3'd2;
	localparam logic [2:0] S_SUM = 3'd3;
	localparam logic [2:0] S_SDIV = 3'd4;
	localparam logic [2:0] S_SWAIT = 3'd5;
	localparam logic [2:0] S_OUT = 3'd6;

	logic [2:0]        state_q;
	logic [SLOT_W-1:0] idx_q;
	logic              ovalid_q;
	logic              acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc = in_valid && in_ready;
	assign out_valid = ovalid_q;

	always_comb begin
		cmd = '0;
		cmd.sum_idx = idx_q;
		cmd.load = acc;
		cmd.do_clear = acc && (req_type == REQ_RESET);
		cmd.do_xfer = acc && (req_type == REQ_XFER);
		unique case (state_q)
			S_IDLE: ;
			S_PDIV: begin
				cmd.div_start = sts.need_permit;
				cmd.sum_clr = 1'b1;
			end
			S_PWAIT: cmd.permit_upd = !sts.div_busy;
			S_SUM: cmd.sum_add = 1'b1;
			S_SDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_speed = 1'b1;
			end
			S_SWAIT: cmd.speed_upd = !sts.div_busy;
			S_OUT: cmd.out_load = !ovalid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (acc) state_q <= S_PDIV;
				S_PDIV: begin
					idx_q <= '0;
					state_q <= sts.need_permit ? S_PWAIT : S_SUM;
				end
				S_PWAIT: if (!sts.div_busy) state_q <= S_SUM;
				S_SUM: begin
					if (idx_q == SLOT_W'(WINDOW_SLOTS - 1)) state_q <= S_SDIV;
					else idx_q <= idx_q + 1'b1;
				end
				S_SDIV: state_q <= S_SWAIT;
				S_SWAIT: if (!sts.div_busy) state_q <= S_OUT;
				S_OUT: if (!ovalid_q || out_ready) begin
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* hw/rtl/transfer_rate_meter_limiter_unit.sv */
// Top level of the two-direction transfer rate meter and limiter.
// Each transaction is either a transfer event (direction, time in us, byte
// count) or a statistics reset, and yields one result: the ring-averaged speed
// of that direction, its next permitted transfer time, the latest activity
// time and whether any cap is set. One transaction at a time: the shared
// 67-step radix-2 divider gives the permit delay (only for a transfer with a
// previous event and a nonzero cap on its direction), a pass sums the five ring
// slots, the divider gives the ring speed. The result register lets the next
// transaction in while a result waits. Caps are written through cfg_we/cfg_idx/cfg_data.
module transfer_rate_meter_limiter_unit
	import trml_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [RATE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 req_type,
	input  logic                 direction,
	input  logic [TIME_W-1:0]    now_us,
	input  logic [CNT_W-1:0]     byte_count,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [RATE_W-1:0]    speed_bytes_per_sec,
	output logic                 next_valid,
	output logic [TIME_W-1:0]    next_time_us,
	output logic [TIME_W-1:0]    last_activity_us,
	output logic                 limiting_active
);
	trml_cmd_t cmd;
	trml_sts_t sts;

	// sequencing
	trml_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	// state, arithmetic and result register
	trml_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_we             (cfg_we),
		.cfg_idx            (cfg_idx),
		.cfg_data           (cfg_data),
		.req_type           (req_type),
		.direction          (direction),
		.now_us             (now_us),
		.byte_count         (byte_count),
		.speed_bytes_per_sec(speed_bytes_per_sec),
		.next_valid         (next_valid),
		.next_time_us       (next_time_us),
		.last_activity_us   (last_activity_us),
		.limiting_active    (limiting_active)
	);
endmodule
